/* design/cfs_pkg.sv */
package cfs_pkg;

   // crc defaults
   localparam logic [7:0] CRC_POLY_RESET = 8'h07;
   localparam logic [7:0] CRC_TOP_BIT    = 8'h80;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // serializer bit counter: data byte then optional check byte
   localparam int BYTE_BITS = 8;
   localparam int BIT_CNT_W = 4;
   localparam logic [BIT_CNT_W-1:0] DATA_END_BIT  = BIT_CNT_W'(BYTE_BITS - 1);
   localparam logic [BIT_CNT_W-1:0] CHECK_END_BIT = BIT_CNT_W'(2 * BYTE_BITS - 1);

   // one job: a data byte, and the check byte when it closes a frame
   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] crc_byte;
      logic       has_crc;
   } job_type;

   // msb-first crc-8 update over one byte
   function automatic logic [7:0] crc_absorb(input logic [7:0] crc_reg,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
      logic [7:0] r;
      r = crc_reg ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((r & CRC_TOP_BIT) != 8'h00) begin
            r = {r[6:0], 1'b0} ^ poly;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

/* design/cfs_front.sv */
module cfs_front
   import cfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata,
   input  logic       req_push,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_data,
   input  logic       q_full,
   output logic       req_full,
   output logic       q_push,
   output job_type    q_job
);

   logic [7:0] poly_ff, poly_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] crc_next;
   logic       accept;

   // polynomial register, always writable
   assign csr_ready = 1'b1;
   assign poly_in   = (csr_valid && csr_ready) ? csr_wdata : poly_ff;

   // accept a beat whenever the job queue has room
   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept;

   // running crc, cleared once the frame closes
   assign crc_next = crc_absorb(crc_ff, req_data_byte, poly_ff);
   always_comb begin
      crc_in = crc_ff;
      if (accept) begin
         crc_in = req_last_data ? 8'h00 : crc_next;
      end
   end

   // job for the serializer
   assign q_job.data_byte = req_data_byte;
   assign q_job.crc_byte  = crc_next;
   assign q_job.has_crc   = req_last_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= CRC_POLY_RESET;
         crc_ff  <= 8'h00;
      end else begin
         poly_ff <= poly_in;
         crc_ff  <= crc_in;
      end
   end

endmodule

/* design/cfs_queue.sv */
module cfs_queue
   import cfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_job
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   // pointer wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   // fill level
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* design/cfs_back.sv */
module cfs_back
   import cfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_job,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output logic    rsp_line_bit,
   output logic    rsp_is_check_bit,
   output logic    rsp_frame_done,
   output logic    rsp_last
);

   logic                 active_ff, active_in;
   logic [15:0]          shift_ff, shift_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 has_crc_ff, has_crc_in;
   logic                 beat_out, end_of_job, load;

   // current bit and its flags
   assign end_of_job       = (cnt_ff == CHECK_END_BIT) ||
                             ((cnt_ff == DATA_END_BIT) && !has_crc_ff);
   assign rsp_empty        = !active_ff;
   assign rsp_line_bit     = shift_ff[15];
   assign rsp_is_check_bit = cnt_ff[BIT_CNT_W-1];
   assign rsp_frame_done   = (cnt_ff == CHECK_END_BIT);
   assign rsp_last         = end_of_job;

   // take the next job when idle or when the last bit leaves
   assign beat_out = rsp_pop && active_ff;
   assign load     = !active_ff || (beat_out && end_of_job);
   assign q_pop    = load && !q_empty;

   always_comb begin
      active_in  = active_ff;
      shift_in   = shift_ff;
      cnt_in     = cnt_ff;
      has_crc_in = has_crc_ff;
      if (load) begin
         active_in  = !q_empty;
         shift_in   = {q_job.data_byte, q_job.crc_byte};
         cnt_in     = '0;
         has_crc_in = q_job.has_crc;
      end else if (beat_out) begin
         shift_in = {shift_ff[14:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      cnt_ff     <= cnt_in;
      has_crc_ff <= has_crc_in;
   end

endmodule

/* design/crc8_frame_serializer.sv */
// CRC-8 frame serializer. Push data bytes with last_data marking the end of a
// frame; each byte comes out as 8 bit beats, MSB first, and a byte flagged
// last_data is followed by the 8 bits of the frame's MSB-first CRC-8 (initial value
// zero, no final XOR, polynomial from the csr write port, 0x07 after reset),
// the final one flagged frame_done. The running CRC up to a byte is formed in
// the cycle it is accepted and travels with it through a two-entry job queue
// to a shift-register serializer that sends one bit per cycle while rsp_pop
// is high; that serializer paces the stream, a byte that closes a frame also
// carrying its check byte. req_full rises only when two jobs wait behind the
// one being sent. Write the polynomial only while no frame is in flight.
module crc8_frame_serializer
   import cfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_line_bit,
   output logic       rsp_is_check_bit,
   output logic       rsp_frame_done,
   output logic       rsp_last
);

   job_type push_job, pop_job;
   logic    q_push, q_full, q_pop, q_empty;

   // classify bytes and run the crc
   cfs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_last_data (req_last_data),
      .q_full        (q_full),
      .req_full      (req_full),
      .q_push        (q_push),
      .q_job         (push_job)
   );

   // job queue
   cfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_job  (pop_job)
   );

   // bit serializer
   cfs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_job            (pop_job),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_line_bit     (rsp_line_bit),
      .rsp_is_check_bit (rsp_is_check_bit),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_last         (rsp_last)
   );

endmodule

/* design/cfs_checker.sv */
module cfs_checker (
   input logic clock,
   input logic reset,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic rsp_line_bit,
   input logic rsp_is_check_bit,
   input logic rsp_frame_done,
   input logic rsp_last
);

   // frame end is the last beat of a check byte
   a_frame_done_flags: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_done) |-> (rsp_last && rsp_is_check_bit))
      else $error("frame_done without last or check bit");

   // a stalled result beat holds its bits
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_line_bit) && $stable(rsp_is_check_bit) &&
          $stable(rsp_frame_done) && $stable(rsp_last)))
      else $error("stalled result beat changed");

   // nothing queued and room after reset
   a_reset_state: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (rsp_empty && !req_full))
      else $error("not empty after reset");

endmodule

bind crc8_frame_serializer cfs_checker u_cfs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_line_bit     (rsp_line_bit),
   .rsp_is_check_bit (rsp_is_check_bit),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_last         (rsp_last)
);
